// File: sv/bnms_pkg.sv
// bnms_pkg: shared types and constants for the 3D box NMS block.
// No dependencies; imported by bnms_iou and box_nms_3d.
`timescale 1ns / 1ps
`default_nettype none

package bnms_pkg;

    localparam int SCORE_W     = 16;
    localparam int THR_W       = 16;
    localparam int KEPT_IDX_W  = 6;
    localparam int RESULT_CAP  = 64;
    localparam int KEPT_CNT_W  = 7;

    localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RK_RD,
        ST_RK_CAP,
        ST_RK_SWEEP,
        ST_RK_WR,
        ST_SP_RD,
        ST_SP_CHK,
        ST_SP_SWEEP,
        ST_SP_DRAIN,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// File: sv/bnms_iou.sv
// bnms_iou: pipelined volume IoU test of two boxes against a Q0.16 threshold.
// Six register stages; depends on bnms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bnms_iou #(
    parameter int CB    = 16,
    parameter int TAG_W = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    input  wire logic [3*CB-1:0]                a_lo,
    input  wire logic [3*CB-1:0]                a_hi,
    input  wire logic signed [3*(CB+1)-1:0]     a_vol,
    input  wire logic [3*CB-1:0]                b_lo,
    input  wire logic [3*CB-1:0]                b_hi,
    input  wire logic signed [3*(CB+1)-1:0]     b_vol,
    input  wire logic [bnms_pkg::THR_W-1:0]     thr,
    input  wire logic [TAG_W-1:0]               in_tag,
    output logic                                busy,
    output logic                                out_valid,
    output logic                                out_hit,
    output logic [TAG_W-1:0]                    out_tag
);
    import bnms_pkg::*;

    localparam int EW = CB + 1;
    localparam int PW = 2 * EW;
    localparam int VW = 3 * EW;
    localparam int UW = VW + 2;
    localparam int MW = UW - 1;
    localparam int LW = (MW + 1) / 2;
    localparam int HW = MW - LW;
    localparam int CW = MW + THR_W;

    logic signed [EW-1:0] ov [3];
    logic                 ok_c;

    // overlap per axis; touching or disjoint clears ok
    always_comb begin
        logic signed [CB-1:0] la, lb, ha, hb, lo, hi;
        ok_c = 1'b1;
        for (int k = 0; k < 3; k++) begin
            la = $signed(a_lo[k*CB +: CB]);
            lb = $signed(b_lo[k*CB +: CB]);
            ha = $signed(a_hi[k*CB +: CB]);
            hb = $signed(b_hi[k*CB +: CB]);
            lo = (la > lb) ? la : lb;
            hi = (ha < hb) ? ha : hb;
            ov[k] = EW'(hi) - EW'(lo);
            if (hi <= lo) begin
                ok_c = 1'b0;
            end
        end
    end

    logic                  s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;
    logic                  s1_ok_reg, s2_ok_reg, s3_ok_reg, s4_ok_reg;
    logic [TAG_W-1:0]      s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg;
    logic [TAG_W-1:0]      s6_tag_reg;
    logic signed [EW-1:0]  s1_ex_reg, s1_ey_reg, s1_ez_reg, s2_ez_reg;
    logic signed [UW-1:0]  s1_vsum_reg, s2_vsum_reg, s3_vsum_reg, s4_uni_reg;
    logic signed [PW-1:0]  s2_ixy_reg;
    logic signed [VW-1:0]  s3_inter_reg;
    logic [VW-1:0]         s4_inter_reg, s5_inter_reg;
    logic                  s5_cand_reg, s6_hit_reg;
    logic [LW+THR_W-1:0]   s5_pl_reg;
    logic [HW+THR_W-1:0]   s5_ph_reg;
    logic [CW-1:0]         rhs, lhs;

    assign rhs = (CW'(s5_ph_reg) << LW) + CW'(s5_pl_reg);
    assign lhs = CW'(s5_inter_reg) << THR_W;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_ok_reg    <= ok_c;
        s1_ex_reg    <= ov[0];
        s1_ey_reg    <= ov[1];
        s1_ez_reg    <= ov[2];
        s1_vsum_reg  <= UW'(a_vol) + UW'(b_vol);
        s1_tag_reg   <= in_tag;

        s2_ok_reg    <= s1_ok_reg;
        s2_ixy_reg   <= s1_ex_reg * s1_ey_reg;
        s2_ez_reg    <= s1_ez_reg;
        s2_vsum_reg  <= s1_vsum_reg;
        s2_tag_reg   <= s1_tag_reg;

        s3_ok_reg    <= s2_ok_reg;
        s3_inter_reg <= s2_ixy_reg * s2_ez_reg;
        s3_vsum_reg  <= s2_vsum_reg;
        s3_tag_reg   <= s2_tag_reg;

        s4_ok_reg    <= s3_ok_reg;
        s4_uni_reg   <= s3_vsum_reg - UW'(s3_inter_reg);
        s4_inter_reg <= s3_inter_reg;
        s4_tag_reg   <= s3_tag_reg;

        // union must be positive; split its magnitude for the threshold product
        s5_cand_reg  <= s4_ok_reg && !s4_uni_reg[UW-1] && (s4_uni_reg != '0);
        s5_pl_reg    <= s4_uni_reg[LW-1:0] * thr;
        s5_ph_reg    <= s4_uni_reg[MW-1:LW] * thr;
        s5_inter_reg <= s4_inter_reg;
        s5_tag_reg   <= s4_tag_reg;

        s6_hit_reg   <= s5_cand_reg && (lhs > rhs);
        s6_tag_reg   <= s5_tag_reg;
    end

    assign busy      = s1_v_reg | s2_v_reg | s3_v_reg | s4_v_reg | s5_v_reg | s6_v_reg;
    assign out_valid = s6_v_reg;
    assign out_hit   = s6_hit_reg;
    assign out_tag   = s6_tag_reg;

endmodule

`default_nettype wire

// File: sv/box_nms_3d.sv
// box_nms_3d: greedy 3D non-maximum suppression with volume IoU, top level.
// Depends on bnms_pkg and bnms_iou.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel s_*: one box per request (six corner coordinates, score,
//   last_box). Boxes are stored in load order, one per cycle, while the block
//   is in its load phase. Boxes beyond MAX_BOXES are dropped, but a dropped
//   box with last_box set still closes the set.
//   Closing a set starts a rank pass and a suppression pass; s_ready stays low
//   until the last kept index of the set has been placed in the output register.
//   Rank pass: one score compare per cycle through the box memory read port.
//   Suppression pass: each kept box goes through the six-stage IoU pipeline;
//   a suppressed box is skipped without it.
//   Output channel m_*: kept load indices in descending score order, the last
//   one flagged by m_last_kept; at most 64 per set.
//   A stalled receiver holds the output register; the suppression pass stops
//   only when a further kept index needs that register.
//   cfg_* writes the IoU threshold (Q0.16); cfg_ready is always high, and
//   writes belong between sets.
//   Reset (aresetn low, synchronous) empties the set, drops any pending output
//   and sets the threshold to 0.5.
module box_nms_3d #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [bnms_pkg::THR_W-1:0]           cfg_thresh,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [COORD_BITS-1:0]         s_x_min,
    input  wire logic signed [COORD_BITS-1:0]         s_y_min,
    input  wire logic signed [COORD_BITS-1:0]         s_z_min,
    input  wire logic signed [COORD_BITS-1:0]         s_x_max,
    input  wire logic signed [COORD_BITS-1:0]         s_y_max,
    input  wire logic signed [COORD_BITS-1:0]         s_z_max,
    input  wire logic [bnms_pkg::SCORE_W-1:0]         s_score,
    input  wire logic                                 s_last_box,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [bnms_pkg::KEPT_IDX_W-1:0]           m_kept_index,
    output logic                                      m_last_kept
);
    import bnms_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int IW  = $clog2(MAX_BOXES);
    localparam int NW  = $clog2(MAX_BOXES + 1);
    localparam int EW  = CB + 1;
    localparam int PW  = 2 * EW;
    localparam int VW  = 3 * EW;
    localparam int KW  = (IW > KEPT_IDX_W) ? IW : KEPT_IDX_W;
    // box memory entry: {score, hi xyz, lo xyz}
    localparam int BW  = 6 * CB + SCORE_W;
    // sorted memory entry: {suppressed, index, volume, hi xyz, lo xyz}
    localparam int SW  = 1 + IW + VW + 6 * CB;
    localparam int O_HI   = 3 * CB;
    localparam int O_VOL  = 6 * CB;
    localparam int O_IDX  = 6 * CB + VW;
    localparam int O_SUPP = SW - 1;
    localparam int TW  = IW + SW;

    state_t state_reg, state_next;

    logic [THR_W-1:0]       thr_reg;
    logic [NW-1:0]          cnt_reg, i_reg, j_reg;
    logic [IW-1:0]          rank_reg, iss_pos_reg, pend_idx_reg;
    logic [BW-1:0]          cur_reg;
    logic signed [PW-1:0]   vxy_reg;
    logic [SW-1:0]          a_reg;
    logic                   iss_v_reg, pend_v_reg;
    logic [KEPT_CNT_W-1:0]  kept_reg;
    logic                   m_valid_reg, m_last_reg;
    logic [KEPT_IDX_W-1:0]  m_idx_reg;

    // memories
    logic [BW-1:0] box_mem [MAX_BOXES];
    logic [BW-1:0] box_rd_reg;
    logic [SW-1:0] srt_mem [MAX_BOXES];
    logic [SW-1:0] srt_rd_reg;

    logic          box_we, box_re, srt_we, srt_re;
    logic [IW-1:0] box_waddr, box_raddr, srt_waddr, srt_raddr;
    logic [BW-1:0] box_wdata;
    logic [SW-1:0] srt_wdata;

    logic accept, out_free, last_i, a_supp, kept_cap, keep, push_mid, push_fin;
    logic rank_hit, drain_done;
    logic signed [EW-1:0] dx, dy, dz;
    logic signed [VW-1:0] vol_c;
    logic [SCORE_W-1:0]   sj, si;
    logic [NW-1:0]        jd;
    logic [KW-1:0]        pend_wide;

    logic          iou_busy, iou_valid, iou_hit;
    logic [TW-1:0] iou_tag;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_i   = (i_reg + NW'(1)) == cnt_reg;
    assign a_supp   = srt_rd_reg[O_SUPP];
    assign kept_cap = (kept_reg + KEPT_CNT_W'(1)) == KEPT_CNT_W'(RESULT_CAP);
    assign drain_done = !iss_v_reg && !iou_busy;

    // stable descending rank: earlier boxes win ties
    assign sj       = box_rd_reg[6*CB +: SCORE_W];
    assign si       = cur_reg[6*CB +: SCORE_W];
    assign jd       = j_reg - NW'(1);
    assign rank_hit = (sj > si) || ((sj == si) && (jd < i_reg));

    // extents of the box being ranked; volume kept with its sorted entry
    assign dx    = EW'($signed(cur_reg[O_HI +: CB]))        - EW'($signed(cur_reg[0 +: CB]));
    assign dy    = EW'($signed(cur_reg[O_HI + CB +: CB]))   - EW'($signed(cur_reg[CB +: CB]));
    assign dz    = EW'($signed(cur_reg[O_HI + 2*CB +: CB])) - EW'($signed(cur_reg[2*CB +: CB]));
    assign vol_c = vxy_reg * dz;

    assign pend_wide = KW'(pend_idx_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept && s_last_box) begin
                    state_next = ST_RK_RD;
                end
            end
            ST_RK_RD:  state_next = ST_RK_CAP;
            ST_RK_CAP: state_next = ST_RK_SWEEP;
            ST_RK_SWEEP: begin
                if (j_reg == cnt_reg) begin
                    state_next = ST_RK_WR;
                end
            end
            ST_RK_WR: begin
                state_next = last_i ? ST_SP_RD : ST_RK_RD;
            end
            ST_SP_RD: state_next = ST_SP_CHK;
            ST_SP_CHK: begin
                if (a_supp) begin
                    state_next = last_i ? ST_FIN : ST_SP_RD;
                end else if (pend_v_reg && !out_free) begin
                    state_next = ST_SP_CHK;
                end else if (kept_cap || last_i) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_SP_SWEEP;
                end
            end
            ST_SP_SWEEP: begin
                if ((j_reg + NW'(1)) == cnt_reg) begin
                    state_next = ST_SP_DRAIN;
                end
            end
            ST_SP_DRAIN: begin
                if (drain_done) begin
                    state_next = last_i ? ST_FIN : ST_SP_RD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = (state_reg == ST_LOAD);
        box_we    = accept && (cnt_reg < NW'(MAX_BOXES));
        box_waddr = cnt_reg[IW-1:0];
        box_wdata = {s_score, s_z_max, s_y_max, s_x_max, s_z_min, s_y_min, s_x_min};
        box_re    = 1'b0;
        box_raddr = i_reg[IW-1:0];
        srt_re    = 1'b0;
        srt_raddr = i_reg[IW-1:0];
        srt_we    = 1'b0;
        srt_waddr = rank_reg;
        srt_wdata = {1'b0, i_reg[IW-1:0], vol_c, cur_reg[O_HI +: 3*CB], cur_reg[0 +: 3*CB]};
        keep      = 1'b0;
        push_fin  = 1'b0;
        case (state_reg)
            ST_RK_RD: begin
                box_re = 1'b1;
            end
            ST_RK_CAP: begin
                box_re    = 1'b1;
                box_raddr = '0;
            end
            ST_RK_SWEEP: begin
                box_re    = (j_reg != cnt_reg);
                box_raddr = j_reg[IW-1:0];
            end
            ST_RK_WR: begin
                srt_we = 1'b1;
            end
            ST_SP_RD: begin
                srt_re = 1'b1;
            end
            ST_SP_CHK: begin
                keep = !a_supp && (!pend_v_reg || out_free);
            end
            ST_SP_SWEEP: begin
                srt_re    = 1'b1;
                srt_raddr = j_reg[IW-1:0];
            end
            ST_FIN: begin
                push_fin = out_free;
            end
            default: begin
            end
        endcase
        // suppression write-back from the IoU pipeline
        if (iou_valid && iou_hit) begin
            srt_we    = 1'b1;
            srt_waddr = iou_tag[TW-1 -: IW];
            srt_wdata = {1'b1, iou_tag[SW-2:0]};
        end
        push_mid = keep && pend_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (box_we) begin
            box_mem[box_waddr] <= box_wdata;
        end
        if (box_re) begin
            box_rd_reg <= box_mem[box_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (srt_we) begin
            srt_mem[srt_waddr] <= srt_wdata;
        end
        if (srt_re) begin
            srt_rd_reg <= srt_mem[srt_raddr];
        end
    end

    bnms_iou #(
        .CB    (CB),
        .TAG_W (TW)
    ) u_iou (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (iss_v_reg),
        .a_lo      (a_reg[0 +: 3*CB]),
        .a_hi      (a_reg[O_HI +: 3*CB]),
        .a_vol     ($signed(a_reg[O_VOL +: VW])),
        .b_lo      (srt_rd_reg[0 +: 3*CB]),
        .b_hi      (srt_rd_reg[O_HI +: 3*CB]),
        .b_vol     ($signed(srt_rd_reg[O_VOL +: VW])),
        .thr       (thr_reg),
        .in_tag    ({iss_pos_reg, srt_rd_reg}),
        .busy      (iou_busy),
        .out_valid (iou_valid),
        .out_hit   (iou_hit),
        .out_tag   (iou_tag)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        vxy_reg     <= dx * dy;
        iss_pos_reg <= j_reg[IW-1:0];
        if (state_reg == ST_RK_CAP) begin
            cur_reg <= box_rd_reg;
        end
        if (keep) begin
            a_reg        <= srt_rd_reg;
            pend_idx_reg <= srt_rd_reg[O_IDX +: IW];
        end
        if (push_mid || push_fin) begin
            m_idx_reg  <= pend_wide[KEPT_IDX_W-1:0];
            m_last_reg <= push_fin;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            thr_reg     <= THR_RESET;
            cnt_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            rank_reg    <= '0;
            iss_v_reg   <= 1'b0;
            pend_v_reg  <= 1'b0;
            kept_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            iss_v_reg <= (state_reg == ST_SP_SWEEP);
            if (cfg_valid) begin
                thr_reg <= cfg_thresh;
            end
            if (box_we) begin
                cnt_reg <= cnt_reg + NW'(1);
            end
            case (state_reg)
                ST_LOAD: begin
                    i_reg <= '0;
                end
                ST_RK_CAP: begin
                    j_reg    <= NW'(1);
                    rank_reg <= '0;
                end
                ST_RK_SWEEP: begin
                    if (j_reg != cnt_reg) begin
                        j_reg <= j_reg + NW'(1);
                    end
                    if (rank_hit) begin
                        rank_reg <= rank_reg + IW'(1);
                    end
                end
                ST_RK_WR: begin
                    i_reg <= last_i ? '0 : i_reg + NW'(1);
                end
                ST_SP_CHK: begin
                    if (a_supp) begin
                        i_reg <= i_reg + NW'(1);
                    end else if (keep) begin
                        pend_v_reg <= 1'b1;
                        kept_reg   <= kept_reg + KEPT_CNT_W'(1);
                        j_reg      <= i_reg + NW'(1);
                    end
                end
                ST_SP_SWEEP: begin
                    j_reg <= j_reg + NW'(1);
                end
                ST_SP_DRAIN: begin
                    if (drain_done) begin
                        i_reg <= i_reg + NW'(1);
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        pend_v_reg <= 1'b0;
                        cnt_reg    <= '0;
                        kept_reg   <= '0;
                    end
                end
                default: begin
                end
            endcase
            if (push_mid || push_fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_kept_index = m_idx_reg;
    assign m_last_kept  = m_last_reg;

endmodule

`default_nettype wire
